[rtl/c2d_pkg.sv]
`timescale 1ns / 1ps
// shared types, widths and codes of the 5x5 convolution block

package c2d_pkg;

  // filter geometry
  localparam int unsigned KDIM   = 5;
  localparam int unsigned NTAPS  = KDIM * KDIM;
  localparam int unsigned NLINES = KDIM - 1;

  // field widths
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned TAP_W     = 16;
  localparam int unsigned TIDX_W    = 5;
  localparam int unsigned PART_W    = 40;
  localparam int unsigned SUM_W     = 40;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned LINE_W    = NLINES * PIX_W;

  // arithmetic widths: product, sum of one tap row, full accumulator
  localparam int unsigned PROD_W = PIX_W + TAP_W;
  localparam int unsigned GRP_W  = PROD_W + 3;
  localparam int unsigned ACC_W  = SUM_W + 2;

  // stream packing
  localparam int unsigned IN_PIX_LO  = 0;
  localparam int unsigned IN_TIDX_LO = IN_PIX_LO + PIX_W;
  localparam int unsigned IN_TVAL_LO = IN_TIDX_LO + TIDX_W;
  localparam int unsigned IN_PART_LO = IN_TVAL_LO + TAP_W;
  localparam int unsigned IN_TDATA_W = 80;
  localparam int unsigned OUT_TDATA_W = 64;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = CFG_IDX_W'(1);

  // plane size limits
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;
  localparam int unsigned DIM_RESET      = 1024;
  localparam int unsigned DIM_MIN        = 5;

  // item kinds carried on tuser
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_TAP   = 1'b1;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef prod_t [NTAPS-1:0] prod_arr_t;

  // position info that follows a result down the pipe
  typedef struct packed {
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             frame_end;
  } meta_t;

endpackage

[rtl/c2d_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram with registered read

module c2d_ram #(
  parameter int unsigned DATA_W = 64,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/c2d_window.sv]
`timescale 1ns / 1ps
// 5x5 window registers, tap registers and the 25 parallel products

module c2d_window (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         shift_en_i,
  input  logic                         prod_en_i,
  input  logic                         tap_en_i,
  input  logic [c2d_pkg::LINE_W-1:0]   line_i,
  input  logic [c2d_pkg::PIX_W-1:0]    pixel_i,
  input  logic [c2d_pkg::TIDX_W-1:0]   tap_index_i,
  input  logic [c2d_pkg::TAP_W-1:0]    tap_value_i,
  output logic [c2d_pkg::LINE_W-1:0]   line_o,
  output c2d_pkg::prod_arr_t           prod_o
);

  import c2d_pkg::*;

  logic signed [PIX_W-1:0] win_q   [NTAPS];
  logic signed [PIX_W-1:0] win_d   [NTAPS];
  logic signed [TAP_W-1:0] taps_q  [NTAPS];
  logic signed [PIX_W-1:0] col_new [KDIM];
  prod_arr_t               prod_d;
  prod_arr_t               prod_q;

  // new column, oldest row first, current pixel at the bottom
  always_comb begin
    for (int i = 0; i < NLINES; i++) begin
      col_new[i] = line_i[i*PIX_W +: PIX_W];
    end
    col_new[KDIM-1] = pixel_i;
  end

  // each line moves up one row, the pixel goes into the newest line
  assign line_o = {pixel_i, line_i[LINE_W-1:PIX_W]};

  always_comb begin
    for (int i = 0; i < KDIM; i++) begin
      for (int j = 0; j < KDIM - 1; j++) begin
        win_d[i*KDIM+j] = win_q[i*KDIM+j+1];
      end
      win_d[i*KDIM+KDIM-1] = col_new[i];
    end
  end

  always_comb begin
    for (int k = 0; k < NTAPS; k++) begin
      prod_d[k] = PROD_W'(win_d[k]) * PROD_W'(taps_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NTAPS; k++) begin
        win_q[k]  <= '0;
        taps_q[k] <= '0;
      end
    end else begin
      if (shift_en_i) begin
        for (int k = 0; k < NTAPS; k++) begin
          win_q[k] <= win_d[k];
        end
      end
      if (tap_en_i && (tap_index_i < TIDX_W'(NTAPS))) begin
        taps_q[tap_index_i] <= tap_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

[rtl/c2d_acc.sv]
`timescale 1ns / 1ps
// two-stage adder tree with saturation and the result register

module c2d_acc (
  input  logic                              clk_i,
  input  logic                              grp_en_i,
  input  logic                              out_en_i,
  input  c2d_pkg::prod_arr_t                prod_i,
  input  logic signed [c2d_pkg::PART_W-1:0] partial_i,
  input  c2d_pkg::meta_t                    meta_i,
  output logic [c2d_pkg::SUM_W-1:0]         sum_o,
  output c2d_pkg::meta_t                    meta_o
);

  import c2d_pkg::*;

  logic signed [GRP_W-1:0]  grp_d [KDIM];
  logic signed [GRP_W-1:0]  grp_q [KDIM];
  logic signed [PART_W-1:0] part_q;
  meta_t                    meta_q;
  logic signed [ACC_W-1:0]  acc;
  logic [SUM_W-1:0]         sat;
  logic [SUM_W-1:0]         sum_q;
  meta_t                    out_meta_q;

  // one sum per tap row
  always_comb begin
    for (int g = 0; g < KDIM; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < KDIM; k++) begin
        grp_d[g] = grp_d[g] + GRP_W'(prod_i[g*KDIM+k]);
      end
    end
  end

  always_comb begin
    acc = ACC_W'(part_q);
    for (int g = 0; g < KDIM; g++) begin
      acc = acc + ACC_W'(grp_q[g]);
    end
  end

  // clip when the result sign bit and the bits above it disagree
  always_comb begin
    if ((&acc[ACC_W-1:SUM_W-1]) || !(|acc[ACC_W-1:SUM_W-1])) begin
      sat = acc[SUM_W-1:0];
    end else if (acc[ACC_W-1]) begin
      sat = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (grp_en_i) begin
      for (int g = 0; g < KDIM; g++) begin
        grp_q[g] <= grp_d[g];
      end
      part_q <= partial_i;
      meta_q <= meta_i;
    end
    if (out_en_i) begin
      sum_q      <= sat;
      out_meta_q <= meta_q;
    end
  end

  assign sum_o  = sum_q;
  assign meta_o = out_meta_q;

endmodule

[rtl/conv2d_5x5_stride1.sv]
`timescale 1ns / 1ps
// top level of the streaming 5x5 stride-1 valid convolution
//
// usage
// - s_axis carries pixels (tuser low) in raster order and filter tap loads
//   (tuser high); a pixel transfer also carries the partial sum for the
//   output window that this pixel completes
// - m_axis returns one result per completed window (row and column both at
//   least four); tlast marks the last result of the plane
// - cfg writes image_width (index 0) and image_height (index 1); both are
//   clamped to five up to MAX_WIDTH (line store size) and MAX_HEIGHT and
//   are to be changed between frames, which the block does not enforce
// - throughput is one item per clock while m_axis is not stalled: four line
//   stores in one ram with a read in the accept cycle and a write when the
//   pixel leaves stage 1, 25 parallel multipliers and a two-level adder tree
// - each stage holds its item only while the stage after it is full, so a
//   stalled receiver fills the empty stages before s_axis_tready drops
// - after reset the line ram is cleared, one column per cycle, while
//   s_axis_tready stays low; cfg writes are taken at any time, and taps,
//   window and counters start at zero

module conv2d_5x5_stride1 #(
  parameter int unsigned MAX_WIDTH  = c2d_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = c2d_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // input stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel, tap_index, tap_value, partial_in, zero pad
  input  logic [c2d_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // kind
  input  logic                                s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_sum, out_row, out_col, zero pad
  output logic [c2d_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // frame_end
  output logic                                m_axis_tlast
);

  import c2d_pkg::*;

  localparam int unsigned WW = $clog2(MAX_WIDTH);
  localparam int unsigned HW = $clog2(MAX_HEIGHT);
  localparam int unsigned W_RST = (DIM_RESET < MAX_WIDTH) ? DIM_RESET : MAX_WIDTH;
  localparam int unsigned H_RST = (DIM_RESET < MAX_HEIGHT) ? DIM_RESET : MAX_HEIGHT;

  // configuration, kept as last column and last row index
  logic [WW-1:0] wm1_q, wm1_new;
  logic [HW-1:0] hm1_q, hm1_new;

  // raster position
  logic [WW-1:0] col_q;
  logic [HW-1:0] row_q;
  logic          last_col, last_row, emit;
  meta_t         meta_in;

  // line ram clearing after reset
  logic          clr_busy_q;
  logic [WW-1:0] clr_addr_q;

  // stage 1: input register, aligned with the ram read data
  logic                     s1_v_q;
  logic                     s1_kind_q;
  logic                     s1_emit_q;
  logic [PIX_W-1:0]         s1_pix_q;
  logic [TIDX_W-1:0]        s1_tidx_q;
  logic [TAP_W-1:0]         s1_tval_q;
  logic signed [PART_W-1:0] s1_part_q;
  logic [WW-1:0]            s1_col_q;
  meta_t                    s1_meta_q;

  // stage 2: products, stage 3: row sums, then the result register
  logic                     s2_v_q, s3_v_q, out_v_q;
  logic signed [PART_W-1:0] s2_part_q;
  meta_t                    s2_meta_q;

  logic          in_xfer, s1_pixel;
  logic          s1_go, s1_rdy, s2_go, s2_rdy, s3_go, s3_rdy, out_rdy;
  logic          ram_we;
  logic [WW-1:0] ram_waddr;
  logic [LINE_W-1:0] ram_wdata, ram_rdata, line_wr;
  prod_arr_t     prod;
  logic [SUM_W-1:0] out_sum;
  meta_t         out_meta;

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i < CFG_DATA_W'(DIM_MIN)) begin
      wm1_new = WW'(DIM_MIN - 1);
    end else if (32'(cfg_data_i) > MAX_WIDTH) begin
      wm1_new = WW'(MAX_WIDTH - 1);
    end else begin
      wm1_new = WW'(cfg_data_i - CFG_DATA_W'(1));
    end
    if (cfg_data_i < CFG_DATA_W'(DIM_MIN)) begin
      hm1_new = HW'(DIM_MIN - 1);
    end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
      hm1_new = HW'(MAX_HEIGHT - 1);
    end else begin
      hm1_new = HW'(cfg_data_i - CFG_DATA_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q <= WW'(W_RST - 1);
      hm1_q <= HW'(H_RST - 1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_WIDTH:  wm1_q <= wm1_new;
        REG_HEIGHT: hm1_q <= hm1_new;
        default:    ;
      endcase
    end
  end

  // -------------------------------------------------------- pipeline flow
  // a stage accepts when empty or when its item leaves in the same cycle;
  // items that give no result end in stage 1
  assign out_rdy = !out_v_q || m_axis_tready;
  assign s3_go   = s3_v_q && out_rdy;
  assign s3_rdy  = !s3_v_q || s3_go;
  assign s2_go   = s2_v_q && s3_rdy;
  assign s2_rdy  = !s2_v_q || s2_go;
  assign s1_go   = s1_v_q && (!s1_emit_q || s2_rdy);
  assign s1_rdy  = !s1_v_q || s1_go;

  assign s_axis_tready = s1_rdy && !clr_busy_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign s1_pixel      = s1_go && (s1_kind_q == KIND_PIXEL);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_v_q <= 1'b1;
      end else if (s1_go) begin
        s1_v_q <= 1'b0;
      end
      if (s1_go && s1_emit_q) begin
        s2_v_q <= 1'b1;
      end else if (s2_go) begin
        s2_v_q <= 1'b0;
      end
      if (s2_go) begin
        s3_v_q <= 1'b1;
      end else if (s3_go) begin
        s3_v_q <= 1'b0;
      end
      if (s3_go) begin
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------ raster counters
  assign last_col = col_q >= wm1_q;
  assign last_row = row_q >= hm1_q;
  assign emit     = (s_axis_tuser == KIND_PIXEL) && (row_q >= HW'(KDIM - 1)) &&
                    (col_q >= WW'(KDIM - 1));

  assign meta_in.row       = POS_W'(row_q - HW'(KDIM - 1));
  assign meta_in.col       = POS_W'(col_q - WW'(KDIM - 1));
  assign meta_in.frame_end = last_col && last_row;

  // counters move on pixel transfers only; a tap load leaves them alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer && (s_axis_tuser == KIND_PIXEL)) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + HW'(1);
      end else begin
        col_q <= col_q + WW'(1);
      end
    end
  end

  // input register, payload only
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_kind_q <= s_axis_tuser;
      s1_emit_q <= emit;
      s1_pix_q  <= s_axis_tdata[IN_PIX_LO +: PIX_W];
      s1_tidx_q <= s_axis_tdata[IN_TIDX_LO +: TIDX_W];
      s1_tval_q <= s_axis_tdata[IN_TVAL_LO +: TAP_W];
      s1_part_q <= s_axis_tdata[IN_PART_LO +: PART_W];
      s1_col_q  <= col_q;
      s1_meta_q <= meta_in;
    end
    if (s1_go && s1_emit_q) begin
      s2_part_q <= s1_part_q;
      s2_meta_q <= s1_meta_q;
    end
  end

  // ------------------------------------------------------------ line ram
  // a column is read when its pixel transfers and written back when that
  // pixel leaves stage 1; the next read of the same column is at least a
  // full row later
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + WW'(1);
      if (clr_addr_q == WW'(MAX_WIDTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_busy_q || s1_pixel;
  assign ram_waddr = clr_busy_q ? clr_addr_q : s1_col_q;
  assign ram_wdata = clr_busy_q ? '0 : line_wr;

  c2d_ram #(
    .DATA_W (LINE_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_xfer && (s_axis_tuser == KIND_PIXEL)),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // ------------------------------------------------- window and products
  c2d_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .shift_en_i  (s1_pixel),
    .prod_en_i   (s1_pixel && s1_emit_q),
    .tap_en_i    (s1_go && (s1_kind_q == KIND_TAP)),
    .line_i      (ram_rdata),
    .pixel_i     (s1_pix_q),
    .tap_index_i (s1_tidx_q),
    .tap_value_i (s1_tval_q),
    .line_o      (line_wr),
    .prod_o      (prod)
  );

  // ------------------------------------------------ sum and saturation
  c2d_acc u_acc (
    .clk_i     (clk_i),
    .grp_en_i  (s2_go),
    .out_en_i  (s3_go),
    .prod_i    (prod),
    .partial_i (s2_part_q),
    .meta_i    (s2_meta_q),
    .sum_o     (out_sum),
    .meta_o    (out_meta)
  );

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_meta.col, out_meta.row, out_sum});
  assign m_axis_tlast  = out_meta.frame_end;

endmodule

[rtl/c2d_checker.sv]
`timescale 1ns / 1ps
// port-level checks of the convolution block and their bind

module c2d_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [c2d_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  // transfers in minus results out, sticky once it saturates
  logic [31:0] bal_q;
  logic        in_xfer, out_xfer;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_q <= '0;
    end else if (&bal_q) begin
      bal_q <= bal_q;
    end else if (in_xfer && !out_xfer) begin
      bal_q <= bal_q + 32'd1;
    end else if (out_xfer && !in_xfer) begin
      bal_q <= bal_q - 32'd1;
    end
  end

  // a stalled result keeps its data and frame mark
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // the line ram is being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during line clear");

  // no result without an earlier input transfer
  a_no_extra_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> (bal_q != 32'd0))
    else $error("more results than input transfers");

  // no result is valid at the edge where reset is first seen released
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result right after reset");

endmodule

bind conv2d_5x5_stride1 c2d_checker u_c2d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
